@@ src/dtel_pkg.sv @@
package dtel_pkg;

  localparam int unsigned PositionWidthDefault = 16;
  localparam int unsigned CharWidth = 16;
  localparam int unsigned TokPosWidth = 16;
  localparam int unsigned FifoDepth = 4;

  localparam logic [2:0] DotsForEllipsis = 3'd3;
  localparam logic [2:0] DotCountMax = 3'd7;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_DOTS = 2'd1,
    MODE_NAME = 2'd2
  } lex_mode_e;

  typedef enum logic [4:0] {
    KIND_INVALID  = 5'd0,
    KIND_BANG     = 5'd1,
    KIND_LPAREN   = 5'd2,
    KIND_RPAREN   = 5'd3,
    KIND_COMMA    = 5'd4,
    KIND_STAR     = 5'd5,
    KIND_COLON    = 5'd6,
    KIND_LT       = 5'd7,
    KIND_EQ       = 5'd8,
    KIND_GT       = 5'd9,
    KIND_QUESTION = 5'd10,
    KIND_LBRACKET = 5'd11,
    KIND_RBRACKET = 5'd12,
    KIND_LBRACE   = 5'd13,
    KIND_PIPE     = 5'd14,
    KIND_RBRACE   = 5'd15,
    KIND_ELLIPSIS = 5'd16,
    KIND_NAME     = 5'd17
  } tok_kind_e;

  localparam logic [15:0] ChrTab      = 16'h0009;
  localparam logic [15:0] ChrCr       = 16'h000D;
  localparam logic [15:0] ChrSpace    = 16'h0020;
  localparam logic [15:0] ChrBang     = 16'h0021;
  localparam logic [15:0] ChrDollar   = 16'h0024;
  localparam logic [15:0] ChrLParen   = 16'h0028;
  localparam logic [15:0] ChrRParen   = 16'h0029;
  localparam logic [15:0] ChrStar     = 16'h002A;
  localparam logic [15:0] ChrComma    = 16'h002C;
  localparam logic [15:0] ChrDot      = 16'h002E;
  localparam logic [15:0] ChrDigit0   = 16'h0030;
  localparam logic [15:0] ChrDigit9   = 16'h0039;
  localparam logic [15:0] ChrColon    = 16'h003A;
  localparam logic [15:0] ChrLt       = 16'h003C;
  localparam logic [15:0] ChrEq       = 16'h003D;
  localparam logic [15:0] ChrGt       = 16'h003E;
  localparam logic [15:0] ChrQuestion = 16'h003F;
  localparam logic [15:0] ChrUpperA   = 16'h0041;
  localparam logic [15:0] ChrUpperZ   = 16'h005A;
  localparam logic [15:0] ChrLBracket = 16'h005B;
  localparam logic [15:0] ChrRBracket = 16'h005D;
  localparam logic [15:0] ChrUnder    = 16'h005F;
  localparam logic [15:0] ChrLowerA   = 16'h0061;
  localparam logic [15:0] ChrLowerZ   = 16'h007A;
  localparam logic [15:0] ChrLBrace   = 16'h007B;
  localparam logic [15:0] ChrPipe     = 16'h007C;
  localparam logic [15:0] ChrRBrace   = 16'h007D;
  localparam logic [15:0] ChrNonAscii = 16'h0080;
  localparam logic [15:0] ChrNbsp     = 16'h00A0;
  localparam logic [15:0] ChrOgham    = 16'h1680;
  localparam logic [15:0] ChrEnQuad   = 16'h2000;
  localparam logic [15:0] ChrHairSp   = 16'h200A;
  localparam logic [15:0] ChrLineSep  = 16'h2028;
  localparam logic [15:0] ChrParaSep  = 16'h2029;
  localparam logic [15:0] ChrNnbsp    = 16'h202F;
  localparam logic [15:0] ChrMmsp     = 16'h205F;
  localparam logic [15:0] ChrIdeoSp   = 16'h3000;
  localparam logic [15:0] ChrBom      = 16'hFEFF;

  typedef struct packed {
    logic      is_space;
    logic      is_dot;
    logic      is_ident_start;
    logic      is_name_part;
    tok_kind_e punct_kind;
  } char_class_t;

  typedef struct packed {
    tok_kind_e               kind;
    logic [TokPosWidth-1:0]  start;
    logic [TokPosWidth-1:0]  stop;
    logic                    dot_err;
    logic                    last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } tok_push_t;

endpackage

@@ src/dtel_classify.sv @@
module dtel_classify (
  input  logic [dtel_pkg::CharWidth-1:0] char_i,
  output dtel_pkg::char_class_t          class_o
);

  logic space;
  logic ident_start;
  logic digit;
  logic dot;
  dtel_pkg::tok_kind_e punct;

  always_comb begin
    space = (char_i == dtel_pkg::ChrSpace) ||
            ((char_i >= dtel_pkg::ChrTab) && (char_i <= dtel_pkg::ChrCr)) ||
            (char_i == dtel_pkg::ChrNbsp) || (char_i == dtel_pkg::ChrOgham) ||
            (char_i == dtel_pkg::ChrLineSep) || (char_i == dtel_pkg::ChrParaSep) ||
            (char_i == dtel_pkg::ChrNnbsp) || (char_i == dtel_pkg::ChrMmsp) ||
            (char_i == dtel_pkg::ChrIdeoSp) || (char_i == dtel_pkg::ChrBom) ||
            ((char_i >= dtel_pkg::ChrEnQuad) && (char_i <= dtel_pkg::ChrHairSp));
  end

  always_comb begin
    if (char_i >= dtel_pkg::ChrNonAscii) begin
      ident_start = !space;
    end else begin
      ident_start = ((char_i >= dtel_pkg::ChrUpperA) && (char_i <= dtel_pkg::ChrUpperZ)) ||
                    ((char_i >= dtel_pkg::ChrLowerA) && (char_i <= dtel_pkg::ChrLowerZ)) ||
                    (char_i == dtel_pkg::ChrDollar) || (char_i == dtel_pkg::ChrUnder);
    end
  end

  assign digit = (char_i >= dtel_pkg::ChrDigit0) && (char_i <= dtel_pkg::ChrDigit9);
  assign dot   = (char_i == dtel_pkg::ChrDot);

  always_comb begin
    unique case (char_i)
      dtel_pkg::ChrBang:     punct = dtel_pkg::KIND_BANG;
      dtel_pkg::ChrLParen:   punct = dtel_pkg::KIND_LPAREN;
      dtel_pkg::ChrRParen:   punct = dtel_pkg::KIND_RPAREN;
      dtel_pkg::ChrComma:    punct = dtel_pkg::KIND_COMMA;
      dtel_pkg::ChrStar:     punct = dtel_pkg::KIND_STAR;
      dtel_pkg::ChrColon:    punct = dtel_pkg::KIND_COLON;
      dtel_pkg::ChrLt:       punct = dtel_pkg::KIND_LT;
      dtel_pkg::ChrEq:       punct = dtel_pkg::KIND_EQ;
      dtel_pkg::ChrGt:       punct = dtel_pkg::KIND_GT;
      dtel_pkg::ChrQuestion: punct = dtel_pkg::KIND_QUESTION;
      dtel_pkg::ChrLBracket: punct = dtel_pkg::KIND_LBRACKET;
      dtel_pkg::ChrRBracket: punct = dtel_pkg::KIND_RBRACKET;
      dtel_pkg::ChrLBrace:   punct = dtel_pkg::KIND_LBRACE;
      dtel_pkg::ChrPipe:     punct = dtel_pkg::KIND_PIPE;
      dtel_pkg::ChrRBrace:   punct = dtel_pkg::KIND_RBRACE;
      default:               punct = dtel_pkg::KIND_INVALID;
    endcase
  end

  always_comb begin
    class_o.is_space       = space;
    class_o.is_dot         = dot;
    class_o.is_ident_start = ident_start;
    class_o.is_name_part   = ident_start || digit || dot;
    class_o.punct_kind     = punct;
  end

endmodule

@@ src/dtel_core.sv @@
module dtel_core #(
  parameter int unsigned PositionWidth = dtel_pkg::PositionWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dtel_pkg::CharWidth-1:0] char_code_i,
  input  logic                           end_of_text_i,
  input  logic                           room_i,
  output dtel_pkg::tok_push_t            push_o
);

  logic                           in_vld_q;
  logic [dtel_pkg::CharWidth-1:0] char_q;
  logic                           eot_q;
  logic                           fire;
  logic                           load;

  dtel_pkg::char_class_t cls;

  dtel_pkg::lex_mode_e      mode_q, mode_d;
  logic [2:0]               dots_q, dots_d;
  logic [PositionWidth-1:0] pstart_q, pstart_d;
  logic [PositionWidth-1:0] pos_q, pos_d;
  logic [PositionWidth-1:0] pos_inc;

  logic               flush_vld;
  logic               single_vld;
  dtel_pkg::token_t   flush_tok;
  dtel_pkg::token_t   single_tok;
  logic               dots_ok;

  // Input register: refill when empty or when the held item is consumed.
  assign fire       = in_vld_q && room_i;
  assign load       = !in_vld_q || fire;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (load) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      char_q <= char_code_i;
      eot_q  <= end_of_text_i;
    end
  end

  dtel_classify u_classify (
    .char_i  (char_q),
    .class_o (cls)
  );

  assign pos_inc = (pos_q == {PositionWidth{1'b1}}) ? pos_q : pos_q + 1'b1;

  // Next lexer state.
  always_comb begin
    mode_d   = mode_q;
    dots_d   = dots_q;
    pstart_d = pstart_q;
    pos_d    = pos_q;
    if (eot_q) begin
      mode_d   = dtel_pkg::MODE_IDLE;
      dots_d   = 3'd0;
      pstart_d = '0;
      pos_d    = '0;
    end else if ((mode_q == dtel_pkg::MODE_DOTS) && cls.is_dot) begin
      dots_d = (dots_q == dtel_pkg::DotCountMax) ? dots_q : dots_q + 3'd1;
      pos_d  = pos_inc;
    end else if ((mode_q == dtel_pkg::MODE_NAME) && cls.is_name_part) begin
      pos_d = pos_inc;
    end else begin
      mode_d = dtel_pkg::MODE_IDLE;
      dots_d = 3'd0;
      pos_d  = pos_inc;
      if (!cls.is_space) begin
        if (cls.is_dot) begin
          mode_d   = dtel_pkg::MODE_DOTS;
          dots_d   = 3'd1;
          pstart_d = pos_q;
        end else if ((cls.punct_kind == dtel_pkg::KIND_INVALID) && cls.is_ident_start) begin
          mode_d   = dtel_pkg::MODE_NAME;
          pstart_d = pos_q;
        end
      end
    end
  end

  // Token outputs: a flushed pending token, then a one-character token.
  always_comb begin
    dots_ok    = (dots_q == dtel_pkg::DotsForEllipsis);
    flush_vld  = 1'b0;
    single_vld = 1'b0;
    if (eot_q) begin
      flush_vld = (mode_q != dtel_pkg::MODE_IDLE);
    end else if (!(((mode_q == dtel_pkg::MODE_DOTS) && cls.is_dot) ||
                   ((mode_q == dtel_pkg::MODE_NAME) && cls.is_name_part))) begin
      flush_vld  = (mode_q != dtel_pkg::MODE_IDLE);
      single_vld = !cls.is_space && !cls.is_dot &&
                   !((cls.punct_kind == dtel_pkg::KIND_INVALID) && cls.is_ident_start);
    end

    flush_tok.start   = dtel_pkg::TokPosWidth'(pstart_q);
    flush_tok.stop    = dtel_pkg::TokPosWidth'(pos_q);
    flush_tok.last    = !single_vld;
    if (mode_q == dtel_pkg::MODE_DOTS) begin
      flush_tok.kind    = dots_ok ? dtel_pkg::KIND_ELLIPSIS : dtel_pkg::KIND_INVALID;
      flush_tok.dot_err = !dots_ok;
    end else begin
      flush_tok.kind    = dtel_pkg::KIND_NAME;
      flush_tok.dot_err = 1'b0;
    end

    single_tok.kind    = cls.punct_kind;
    single_tok.start   = dtel_pkg::TokPosWidth'(pos_q);
    single_tok.stop    = dtel_pkg::TokPosWidth'(pos_inc);
    single_tok.dot_err = 1'b0;
    single_tok.last    = 1'b1;
  end

  // Compact the two slots so the first pushed token is always tok0.
  always_comb begin
    push_o.cnt  = 2'd0;
    push_o.tok0 = flush_vld ? flush_tok : single_tok;
    push_o.tok1 = single_tok;
    if (fire) begin
      push_o.cnt = {1'b0, flush_vld} + {1'b0, single_vld};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= dtel_pkg::MODE_IDLE;
      dots_q   <= 3'd0;
      pstart_q <= '0;
      pos_q    <= '0;
    end else if (fire) begin
      mode_q   <= mode_d;
      dots_q   <= dots_d;
      pstart_q <= pstart_d;
      pos_q    <= pos_d;
    end
  end

endmodule

@@ src/dtel_tok_fifo.sv @@
module dtel_tok_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtel_pkg::tok_push_t push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dtel_pkg::token_t    tok_o
);

  localparam int unsigned PtrWidth = $clog2(dtel_pkg::FifoDepth);
  localparam int unsigned CntWidth = $clog2(dtel_pkg::FifoDepth + 1);

  dtel_pkg::token_t    mem_q [dtel_pkg::FifoDepth];
  logic [PtrWidth-1:0] wr_q, rd_q;
  logic [PtrWidth-1:0] wr_next;
  logic [CntWidth-1:0] cnt_q;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign tok_o       = mem_q[rd_q];
  // Room for two tokens without counting on a pop this cycle.
  assign room_o      = (cnt_q <= CntWidth'(dtel_pkg::FifoDepth - 2));
  assign wr_next     = wr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrWidth'(push_i.cnt);
      rd_q  <= rd_q + PtrWidth'(pop);
      cnt_q <= cnt_q + CntWidth'(push_i.cnt) - CntWidth'(pop);
    end
  end

endmodule

@@ src/doc_type_expression_lexer.sv @@
// Streaming lexer for documentation type expressions. Feed one UTF-16 code
// unit per input item; set end_of_text_i to close the text (the code unit is
// then ignored, any pending dot run or name is flushed and the position
// counter restarts at 0). Whitespace is skipped. The block returns tokens
// with kind, start and end position: fifteen single-character punctuators,
// an ellipsis for a run of exactly three dots (any other run gives an invalid
// token with dot_error_o set), names, and one-character invalid tokens.
// A dot run or name is only reported when the first unit that cannot extend
// it arrives or the text is closed, so one item can produce two tokens;
// last_of_item_o marks the final token of an item. The position counter is
// POSITION_WIDTH bits wide, saturates, and reports its low 16 bits.
// Throughput is one item per clock as long as each item yields at most one
// token and the output is not stalled; the output side delivers one token
// per clock while out_stall_i is low, so the two tokens of one item leave
// one after the other. A token passes from the input register, which feeds
// the classifier and lexer state, into a four-entry token queue that drives
// the output ports. Input stalls while an item waits in the input register
// and the queue cannot take two more tokens.
module doc_type_expression_lexer #(
  parameter int unsigned POSITION_WIDTH = dtel_pkg::PositionWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dtel_pkg::CharWidth-1:0]   char_code_i,
  input  logic                             end_of_text_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [4:0]                       token_kind_o,
  output logic [dtel_pkg::TokPosWidth-1:0] token_start_o,
  output logic [dtel_pkg::TokPosWidth-1:0] token_end_o,
  output logic                             dot_error_o,
  output logic                             last_of_item_o
);

  dtel_pkg::tok_push_t push;
  dtel_pkg::token_t    tok;
  logic                room;

  // Lexer: input register, character classes and mode update.
  dtel_core #(
    .PositionWidth (POSITION_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .room_i        (room),
    .push_o        (push)
  );

  // Token queue: decouple the two-token bursts from the output handshake.
  dtel_tok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tok_o       (tok)
  );

  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_end_o    = tok.stop;
  assign dot_error_o    = tok.dot_err;
  assign last_of_item_o = tok.last;

endmodule
